// ----- sv/mavg_pkg.sv -----
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared types and constants for the moving average filter: control states,
// register map and the window size register layout.
// ----------------------------------------------------------------------------
package mavg_pkg;

    // control states of the filter sequencer
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } mavg_state_t;

    // configuration port layout
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;

    // register map, as word indexes
    localparam int REG_WINDOW_SIZE = 0;

    // window size register
    localparam int          WINDOW_SIZE_BITS  = 6;
    localparam logic [5:0]  WINDOW_SIZE_RESET = 6'd15;

endpackage

// ----- sv/moving_average_filter.sv -----
// ----------------------------------------------------------------------------
// moving_average_filter
// Boxcar moving average with warm-up over a ring of up to MAX_WINDOW samples.
// Keeps a running sum and a fill count; divides by the fill count while the
// ring fills and by the window size once it is full, then drops the oldest.
// ----------------------------------------------------------------------------
// flow: an accepted sample updates the sum, the bit-serial divider then
//   produces one quotient bit a cycle, and the final state loads the average
//   into the output register once the output can take it; a new sample is
//   accepted only after that, back in the idle state
// reset: window 15; sum, fill count, oldest pointer cleared, write pointer at
//   the last slot; ring contents not cleared and only read after being written
module moving_average_filter
    import mavg_pkg::*;
#(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                                 s_axis_tuser,  // [0] restart
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // [SAMPLE_BITS-1:0] average
    output logic                                 m_axis_tuser,  // [0] window_full
    // configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [PADDR_W-1:0]                   paddr,
    input  logic [PDATA_W-1:0]                   pwdata,
    output logic [PDATA_W-1:0]                   prdata,
    output logic                                 pready
);

    localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CW      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_BITS + CW;

    // clamp the window register to 1..MAX_WINDOW
    function automatic logic [CW-1:0] win_eff_of(input logic [WINDOW_SIZE_BITS-1:0] v);
        logic [CW-1:0] r;
        if (v == '0)
        begin
            r = CW'(1);
        end
        else if (32'(v) > MAX_WINDOW)
        begin
            r = CW'(MAX_WINDOW);
        end
        else
        begin
            r = CW'(v);
        end
        return r;
    endfunction

    mavg_state_t                 state_reg, state_next;
    logic [WINDOW_SIZE_BITS-1:0] window_reg, window_next;
    logic [SW-1:0]               write_slot_reg, write_slot_next;
    logic [SW-1:0]               oldest_slot_reg, oldest_slot_next;
    logic signed [SUM_W-1:0]     sum_reg, sum_next;
    logic [CW-1:0]               count_reg, count_next;
    logic                        full_reg, full_next;
    logic                        sign_reg, sign_next;
    logic                        out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0]      out_avg_reg, out_avg_next;
    logic                        out_full_reg, out_full_next;

    logic [SAMPLE_BITS-1:0]      ring [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]      rd_data_reg;

    logic [CW-1:0]               win_eff;
    logic                        cfg_wr;
    logic                        in_xfer;
    logic [SAMPLE_BITS-1:0]      sample;
    logic signed [SUM_W-1:0]     sample_ext;
    logic signed [SUM_W-1:0]     old_ext;
    logic [SW-1:0]               slot_base;
    logic [SW-1:0]               slot_new;
    logic [SW-1:0]               oldest_base;
    logic signed [SUM_W-1:0]     sum_base;
    logic signed [SUM_W-1:0]     sum_new;
    logic [CW-1:0]               count_base;
    logic [CW-1:0]               count_new;
    logic [CW-1:0]               oldest_inc;
    logic [SUM_W-1:0]            magnitude;
    logic                        div_start;
    logic                        div_done;
    logic [SUM_W-1:0]            quotient;
    logic [SAMPLE_BITS-1:0]      q_low;

    assign win_eff    = win_eff_of(window_reg);
    assign cfg_wr     = psel && penable && pwrite && pready
                        && ((32'(paddr) >> 2) == REG_WINDOW_SIZE);
    assign in_xfer    = s_axis_tvalid && s_axis_tready;
    assign sample     = s_axis_tdata[SAMPLE_BITS-1:0];
    assign sample_ext = {{(SUM_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
    assign old_ext    = {{(SUM_W-SAMPLE_BITS){rd_data_reg[SAMPLE_BITS-1]}}, rd_data_reg};

    // restart takes effect before the new sample
    always_comb
    begin
        slot_base   = s_axis_tuser ? SW'(win_eff - CW'(1)) : write_slot_reg;
        oldest_base = s_axis_tuser ? '0 : oldest_slot_reg;
        sum_base    = s_axis_tuser ? '0 : sum_reg;
        count_base  = s_axis_tuser ? '0 : count_reg;
        slot_new    = (CW'(slot_base) >= (win_eff - CW'(1))) ? '0 : slot_base + 1'b1;
        sum_new     = sum_base + sample_ext;
        count_new   = count_base + 1'b1;
        magnitude   = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
        oldest_inc  = CW'(oldest_slot_reg) + 1'b1;
        q_low       = quotient[SAMPLE_BITS-1:0];
    end

    // sequencer and next-state logic
    always_comb
    begin
        state_next       = state_reg;
        window_next      = window_reg;
        write_slot_next  = write_slot_reg;
        oldest_slot_next = oldest_slot_reg;
        sum_next         = sum_reg;
        count_next       = count_reg;
        full_next        = full_reg;
        sign_next        = sign_reg;
        out_valid_next   = out_valid_reg;
        out_avg_next     = out_avg_reg;
        out_full_next    = out_full_reg;
        s_axis_tready    = 1'b0;
        div_start        = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    write_slot_next  = slot_new;
                    oldest_slot_next = oldest_base;
                    sum_next         = sum_new;
                    count_next       = count_new;
                    full_next        = (count_new >= win_eff);
                    sign_next        = sum_new[SUM_W-1];
                    div_start        = 1'b1;
                    state_next       = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_avg_next   = sign_reg ? SAMPLE_BITS'(-q_low) : q_low;
                    out_full_next  = full_reg;
                    // drop the oldest sample once the window is full
                    if (full_reg)
                    begin
                        sum_next         = sum_reg - old_ext;
                        oldest_slot_next = (oldest_inc >= win_eff) ? '0 : SW'(oldest_inc);
                        count_next       = count_reg - 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // window size write clears the running state
        if (cfg_wr)
        begin
            window_next      = pwdata[WINDOW_SIZE_BITS-1:0];
            write_slot_next  = SW'(win_eff_of(pwdata[WINDOW_SIZE_BITS-1:0]) - CW'(1));
            oldest_slot_next = '0;
            sum_next         = '0;
            count_next       = '0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            window_reg      <= WINDOW_SIZE_RESET;
            write_slot_reg  <= SW'(win_eff_of(WINDOW_SIZE_RESET) - CW'(1));
            oldest_slot_reg <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            window_reg      <= window_next;
            write_slot_reg  <= write_slot_next;
            oldest_slot_reg <= oldest_slot_next;
            sum_reg         <= sum_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        full_reg     <= full_next;
        sign_reg     <= sign_next;
        out_avg_reg  <= out_avg_next;
        out_full_reg <= out_full_next;
    end

    // sample ring, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ring[slot_new] <= sample;
        end
        rd_data_reg <= ring[oldest_slot_reg];
    end

    // serial divide of |sum| by the sample count
    mavg_div #(
        .DVD_W (SUM_W),
        .DVS_W (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (magnitude),
        .divisor  (count_new),
        .done     (div_done),
        .quotient (quotient)
    );

    // output stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'(out_avg_reg);
    assign m_axis_tuser  = out_full_reg;

    // configuration readback
    assign pready = 1'b1;
    assign prdata = ((32'(paddr) >> 2) == REG_WINDOW_SIZE) ? PDATA_W'(window_reg) : '0;

    // fill count never exceeds the effective window
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= win_eff)
        else $error("fill count above window size");

    // pointers stay inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        (CW'(write_slot_reg) < win_eff) && (CW'(oldest_slot_reg) < win_eff))
        else $error("ring pointer outside window");

    // an input transfer starts a division
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_DIV))
        else $error("input transfer did not start division");

    // a result is only produced by the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result produced outside final state");

endmodule

// ----- sv/mavg_div.sv -----
// ----------------------------------------------------------------------------
// mavg_div
// Bit-serial restoring divider for unsigned magnitudes. The dividend sits in
// a shift register that moves left one bit per cycle while quotient bits
// enter at the bottom, so after DVD_W steps the register holds the quotient.
// ----------------------------------------------------------------------------
module mavg_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // one restoring step: shift in the next dividend bit and try a subtract
    always_comb
    begin
        trial = {rem_reg, dvd_reg[DVD_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W - 1);
            dvd_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], fits};
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath shift registers
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // last step lands at this edge, quotient is ready right after it
    assign done     = busy_reg && (cnt_reg == '0);
    assign quotient = dvd_reg;

endmodule

// ----- tb/mavg_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mavg_checker
// Watches the sample, average and configuration channels of the moving
// average filter. Keeps its own copy of the window, running sum and fill
// count, works out the average each accepted sample must produce, and
// compares every average transfer field by field against the oldest one due.
// ----------------------------------------------------------------------------
module mavg_checker
    import mavg_pkg::*;
#(
    parameter int MAX_WINDOW  = 32,
    parameter int SAMPLE_BITS = 16,
    parameter int TDATA_W     = ((SAMPLE_BITS+7)/8)*8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    input  logic [TDATA_W-1:0]  s_axis_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic                s_axis_tuser,   // [0] restart
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    input  logic [TDATA_W-1:0]  m_axis_tdata,   // [SAMPLE_BITS-1:0] average
    input  logic                m_axis_tuser,   // [0] window_full
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic                pready,
    output int                  averages_due,
    output int                  fail_count
);

    typedef struct packed
    {
        logic signed [SAMPLE_BITS-1:0] average;
        logic                          window_full;
    } average_t;

    // predicted filter state
    logic [WINDOW_SIZE_BITS-1:0]   window_reg;
    logic signed [SAMPLE_BITS-1:0] sample_ring [MAX_WINDOW];
    int                            write_slot;
    int                            oldest_slot;
    int                            fill_count;
    longint                        running_sum;

    average_t                      due_averages [$];
    average_t                      want;

    // window length actually in force
    function automatic int active_window();
        if (window_reg == 0)
            return 1;
        if (window_reg > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(window_reg);
    endfunction

    function automatic void clear_window();
        write_slot  = active_window() - 1;
        oldest_slot = 0;
        running_sum = 0;
        fill_count  = 0;
    endfunction

    // take one sample into the window and return the average it produces
    function automatic average_t take_sample(logic signed [SAMPLE_BITS-1:0] sample,
                                             logic restart);
        int       n;
        average_t res;
        n = active_window();
        if (restart)
            clear_window();
        write_slot = (write_slot >= n - 1) ? 0 : write_slot + 1;
        sample_ring[write_slot] = sample;
        running_sum += sample;
        fill_count++;
        if (fill_count >= n)
        begin
            // full window: average over n, then retire the oldest sample
            res.average     = SAMPLE_BITS'(running_sum / n);
            res.window_full = 1'b1;
            running_sum    -= sample_ring[oldest_slot];
            oldest_slot     = (oldest_slot + 1 >= n) ? 0 : oldest_slot + 1;
            fill_count--;
        end
        else
        begin
            res.average     = SAMPLE_BITS'(running_sum / fill_count);
            res.window_full = 1'b0;
        end
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= 20)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // channel monitor: config writes, average checks, sample predictions
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            window_reg = WINDOW_SIZE_RESET;
            foreach (sample_ring[i])
                sample_ring[i] = '0;
            clear_window();
            due_averages.delete();
            fail_count   = 0;
            averages_due <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready &&
                paddr == PADDR_W'(REG_WINDOW_SIZE * 4))
            begin
                window_reg = pwdata[WINDOW_SIZE_BITS-1:0];
                clear_window();
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_averages.size() == 0)
                    report_mismatch($sformatf("average %0d with no sample pending",
                                              $signed(m_axis_tdata[SAMPLE_BITS-1:0])));
                else
                begin
                    want = due_averages.pop_front();
                    if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.average)
                        report_mismatch($sformatf("average %0d, predicted %0d",
                                                  $signed(m_axis_tdata[SAMPLE_BITS-1:0]),
                                                  want.average));
                    if (m_axis_tuser !== want.window_full)
                        report_mismatch($sformatf("window_full %b, predicted %b",
                                                  m_axis_tuser, want.window_full));
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                due_averages.push_back(take_sample(s_axis_tdata[SAMPLE_BITS-1:0],
                                                   s_axis_tuser));

            averages_due <= due_averages.size();
        end
    end

endmodule

// ----- tb/tb_moving_average_filter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moving_average_filter
// Drives samples and window size writes into the moving average filter with
// random gaps on the sample side and random stalls on the average side. A
// directed opening covers extreme samples, truncation toward zero, restart
// and out-of-range window sizes; random phases then sweep window settings.
// ----------------------------------------------------------------------------
module tb_moving_average_filter;
    import mavg_pkg::*;

    localparam int MAX_WINDOW  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int TDATA_W     = ((SAMPLE_BITS+7)/8)*8;
    localparam int ITEM_TOTAL  = 1350;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [TDATA_W-1:0]  s_axis_tdata = '0;     // [SAMPLE_BITS-1:0] sample
    logic                s_axis_tuser = 1'b0;   // [0] restart
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;          // [SAMPLE_BITS-1:0] average
    logic                m_axis_tuser;          // [0] window_full
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [PDATA_W-1:0]  pwdata = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int                  averages_due;
    int                  fail_count;
    bit                  calm_tail = 1'b0;

    always #5 clk = ~clk;

    moving_average_filter #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mavg_checker #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .averages_due  (averages_due),
        .fail_count    (fail_count)
    );

    // one sample transfer; tvalid stays high afterwards for back-to-back items
    task automatic send_sample(logic [SAMPLE_BITS-1:0] sample, logic restart);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(sample);
        s_axis_tuser  <= restart;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // let every pending average drain, then write the window size register
    task automatic set_window(logic [PDATA_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (averages_due != 0)
            @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(REG_WINDOW_SIZE * 4);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // mostly full-range samples, with the extremes and small values mixed in
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(int heavy);
        if (heavy == 1)
            return 16'h7FFF;
        if (heavy == 2)
            return 16'h8000;
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed(5'($urandom_range(0, 31))));
            default: return 16'($urandom());
        endcase
    endfunction

    // average side: random stall bursts, none in the calm tail
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!calm_tail && $urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        int             items_left;
        int             phase;
        int             count;
        int             heavy;
        int             gap_odds;
        logic [5:0]     win;
        logic [5:0]     sweep [5];

        sweep = '{6'd32, 6'd63, 6'd0, 6'd1, 6'd33};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset window of 15: extremes, truncation of negative means, restart
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);

        // window size zero behaves as one
        set_window(32'd0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'hFFFF, 1'b1);

        // window of two: rounding toward zero and the most negative sum
        set_window(32'd2);
        send_sample(-16'sd3, 1'b0);
        send_sample(-16'sd4, 1'b0);
        send_sample(16'd7, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);

        // random phases over window settings
        items_left = ITEM_TOTAL - 15;
        phase = 0;
        while (items_left > 0)
        begin
            win = (phase < 5) ? sweep[phase] : 6'($urandom_range(0, 63));
            if ($urandom_range(0, 1) == 0)
                set_window(PDATA_W'(win));
            else
                set_window(($urandom() & ~32'h3F) | PDATA_W'(win));
            count = $urandom_range(30, 110);
            if (count > items_left)
                count = items_left;
            heavy = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
            gap_odds = $urandom_range(0, 6);
            repeat (count)
            begin
                if (items_left < 120)
                    calm_tail = 1'b1;
                if (!calm_tail && gap_odds != 0 && $urandom_range(0, gap_odds) == 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 18)) @(posedge clk);
                end
                send_sample(pick_sample(heavy), $urandom_range(0, 15) == 0);
                items_left--;
            end
            phase++;
        end

        // drain and settle
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (averages_due != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (fail_count == 0)
            $display("moving_average_filter test passed");
        else
            $display("moving_average_filter test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("moving_average_filter test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/mavg_pkg.sv
sv/mavg_div.sv
sv/moving_average_filter.sv
tb/mavg_checker.sv
tb/tb_moving_average_filter.sv
